@@ hdl/owlr_pkg.sv @@
// ----------------------------------------------------------------------------
// owlr_pkg
// Shared types and constants for the overwriting byte trace ring.
// ----------------------------------------------------------------------------
package owlr_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TOTAL_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

endpackage

@@ hdl/overwrite_log_ring_with_since_read_top.sv @@
// ----------------------------------------------------------------------------
// overwrite_log_ring_with_since_read_top
// Byte trace ring of DEPTH entries that overwrites its oldest byte when full,
// with a 32-bit running write total and a read-since-total stream.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   kind selects write (store data_byte), read (stream bytes newer than
//   since_total) or clear (empty the ring, keep the total).
//   Writes and clears produce no result; busy stays low.
//   A read of n held bytes raises busy while its store reads run, one per
//   cycle on the single read port of the byte memory; the results follow
//   one per cycle from the read data register, after the stream state,
//   marked by strobe, oldest first, last on the final one.
//   A read with nothing new gives one result with byte_valid low in the
//   cycle after the transaction and keeps busy low.
//   So writes run at one per cycle, a read of n bytes holds off the next
//   transaction while busy, and a read with nothing new holds off none.
//   The receiver cannot stall: each result is shown for one cycle only.
//   Reset (rst, synchronous) empties the ring, zeroes the total and drops
//   any stream in progress; the byte memory itself is not cleared.
// ----------------------------------------------------------------------------
module overwrite_log_ring_with_since_read_top
  import owlr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [TOTAL_W-1:0] since_total,
  output logic               strobe,
  output logic [BYTE_W-1:0]  byte_out,
  output logic               byte_valid,
  output logic               overflow,
  output logic [TOTAL_W-1:0] current_total,
  output logic               last
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = $clog2(2 * DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];

  state_t             state;
  logic [PTR_W-1:0]   write_pos;
  logic [CNT_W-1:0]   fill_count;
  logic [TOTAL_W-1:0] write_total;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   remain;
  logic [BYTE_W-1:0]  rd_data;
  logic               out_strobe;
  logic               out_valid;
  logic               out_last;
  logic               ovf_q;
  logic [TOTAL_W-1:0] total_q;

  logic               accept;
  kind_t              kind_in;
  logic [TOTAL_W-1:0] wanted;
  logic               ovf_calc;
  logic [CNT_W-1:0]   n_calc;
  logic [SUM_W-1:0]   pos_sum;
  logic [PTR_W-1:0]   start_pos;
  logic [PTR_W-1:0]   write_pos_next;
  logic [PTR_W-1:0]   rd_ptr_next;

  assign accept  = start && !busy;
  assign kind_in = kind_t'(kind);
  assign busy    = (state == ST_STREAM);

  assign wanted   = write_total - since_total;
  assign ovf_calc = wanted > TOTAL_W'(fill_count);
  assign n_calc   = ovf_calc ? fill_count : wanted[CNT_W-1:0];

  // oldest requested entry: write_pos - n modulo DEPTH
  assign pos_sum   = SUM_W'(write_pos) + SUM_W'(DEPTH) - SUM_W'(n_calc);
  assign start_pos = (pos_sum >= SUM_W'(DEPTH)) ? PTR_W'(pos_sum - SUM_W'(DEPTH))
                                                : PTR_W'(pos_sum);

  assign write_pos_next = (write_pos == PTR_W'(DEPTH - 1)) ? '0 : write_pos + 1'b1;
  assign rd_ptr_next    = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // byte memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && kind_in == KIND_WRITE) begin
      mem[write_pos] <= data_byte;
    end
    if (state == ST_STREAM) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_pos   <= '0;
      fill_count  <= '0;
      write_total <= '0;
      remain      <= '0;
      out_strobe  <= 1'b0;
      out_valid   <= 1'b0;
      out_last    <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (kind_in)
              KIND_WRITE: begin
                write_pos   <= write_pos_next;
                write_total <= write_total + 1'b1;
                if (fill_count != CNT_W'(DEPTH)) begin
                  fill_count <= fill_count + 1'b1;
                end
              end
              KIND_CLEAR: begin
                write_pos  <= '0;
                fill_count <= '0;
              end
              KIND_READ: begin
                ovf_q   <= ovf_calc;
                total_q <= write_total;
                if (n_calc == '0) begin
                  out_strobe <= 1'b1;
                  out_valid  <= 1'b0;
                  out_last   <= 1'b1;
                end else begin
                  rd_ptr <= start_pos;
                  remain <= n_calc;
                  state  <= ST_STREAM;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_STREAM: begin
          out_strobe <= 1'b1;
          out_valid  <= 1'b1;
          out_last   <= (remain == CNT_W'(1));
          rd_ptr     <= rd_ptr_next;
          remain     <= remain - 1'b1;
          if (remain == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign strobe        = out_strobe;
  assign byte_out      = out_valid ? rd_data : '0;
  assign byte_valid    = out_valid;
  assign overflow      = ovf_q;
  assign current_total = total_q;
  assign last          = out_last;

endmodule

@@ hdl/owlr_checker.sv @@
// ----------------------------------------------------------------------------
// owlr_checker
// Port-level checks on the trace ring's result stream, bound to the top.
// ----------------------------------------------------------------------------
module owlr_checker
  import owlr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [KIND_W-1:0]  kind,
  input logic               strobe,
  input logic               byte_valid,
  input logic               overflow,
  input logic [TOTAL_W-1:0] current_total,
  input logic               last
);

  // an empty answer is a single result
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !byte_valid |-> last)
    else $error("empty result without last");

  // a read streams without gaps
  a_stream_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a read stream");

  // total and overflow are constant across one read
  a_stream_fields_stable: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> $stable(current_total) && $stable(overflow))
    else $error("per-read fields changed within a stream");

  // a write transaction yields no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_WRITE |=> !strobe)
    else $error("result after a write transaction");

endmodule

bind overwrite_log_ring_with_since_read_top owlr_checker u_owlr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .kind          (kind),
  .strobe        (strobe),
  .byte_valid    (byte_valid),
  .overflow      (overflow),
  .current_total (current_total),
  .last          (last)
);

@@ bench/trace_ring_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trace_ring_checker
// Watches the command and result channels of the overwriting byte trace ring.
// It keeps its own copy of the ring, the fill count and the running write
// total, works out the bytes every accepted read must stream, and compares
// each strobed result field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module trace_ring_checker
  import owlr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [TOTAL_W-1:0] since_total,
  input  logic               strobe,
  input  logic [BYTE_W-1:0]  byte_out,
  input  logic               byte_valid,
  input  logic               overflow,
  input  logic [TOTAL_W-1:0] current_total,
  input  logic               last,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               valid;
    logic               ovf;
    logic [TOTAL_W-1:0] total;
    logic               fin;
  } trace_byte_t;

  trace_byte_t        read_bytes_due[$];
  logic [BYTE_W-1:0]  ring_copy[DEPTH];
  int unsigned        ring_wr_pos;
  int unsigned        ring_fill;
  logic [TOTAL_W-1:0] ring_total;

  task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                 input logic [TOTAL_W-1:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic apply_ring_transaction(input logic [KIND_W-1:0] k,
                                        input logic [BYTE_W-1:0] d,
                                        input logic [TOTAL_W-1:0] since);
    logic [TOTAL_W-1:0] wanted;
    logic               ovf;
    int unsigned        n;
    int unsigned        pos;
    trace_byte_t        rec;
    case (k)
      KIND_WRITE: begin
        ring_copy[IDX_W'(ring_wr_pos)] = d;
        ring_wr_pos = (ring_wr_pos + 1) % DEPTH;
        if (ring_fill < DEPTH) ring_fill++;
        ring_total = ring_total + 1'b1;
      end
      KIND_CLEAR: begin
        ring_wr_pos = 0;
        ring_fill = 0;
      end
      KIND_READ: begin
        wanted = ring_total - since;
        ovf = (wanted > TOTAL_W'(ring_fill));
        n = ovf ? ring_fill : int'(wanted);
        if (n == 0) begin
          rec = '{data: '0, valid: 1'b0, ovf: ovf, total: ring_total, fin: 1'b1};
          read_bytes_due.push_back(rec);
        end else begin
          pos = (ring_wr_pos + DEPTH - n) % DEPTH;
          for (int unsigned i = 0; i < n; i++) begin
            rec = '{data: ring_copy[IDX_W'(pos)], valid: 1'b1, ovf: ovf,
                    total: ring_total, fin: (i + 1 == n)};
            read_bytes_due.push_back(rec);
            pos = (pos + 1) % DEPTH;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    trace_byte_t want;
    if (rst) begin
      read_bytes_due.delete();
      ring_wr_pos = 0;
      ring_fill = 0;
      ring_total = '0;
    end else begin
      if (strobe === 1'b1) begin
        if (read_bytes_due.size() == 0) begin
          report_mismatch("unexpected result, byte_out", TOTAL_W'(byte_out), '0);
        end else begin
          want = read_bytes_due.pop_front();
          if (byte_out !== want.data)
            report_mismatch("byte_out", TOTAL_W'(byte_out), TOTAL_W'(want.data));
          if (byte_valid !== want.valid)
            report_mismatch("byte_valid", TOTAL_W'(byte_valid), TOTAL_W'(want.valid));
          if (overflow !== want.ovf)
            report_mismatch("overflow", TOTAL_W'(overflow), TOTAL_W'(want.ovf));
          if (current_total !== want.total)
            report_mismatch("current_total", current_total, want.total);
          if (last !== want.fin)
            report_mismatch("last", TOTAL_W'(last), TOTAL_W'(want.fin));
        end
      end else if (strobe !== 1'b0) begin
        report_mismatch("strobe unknown", TOTAL_W'(strobe), '0);
      end
      if (start === 1'b1 && busy === 1'b0)
        apply_ring_transaction(kind, data_byte, since_total);
    end
    pending_count = read_bytes_due.size();
  end

endmodule

@@ bench/overwrite_log_ring_with_since_read_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwrite_log_ring_with_since_read_top_tb
// Drives writes, reads since a cursor, clears and ignored commands into the
// overwriting byte trace ring: a short directed sequence first, then random
// write bursts, reads with near, exact, ahead and random cursors, and clears,
// with random gaps. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module overwrite_log_ring_with_since_read_top_tb;
  import owlr_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          ITEM_GOAL   = 250;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  data_byte;
  logic [TOTAL_W-1:0] since_total;
  logic               strobe;
  logic [BYTE_W-1:0]  byte_out;
  logic               byte_valid;
  logic               overflow;
  logic [TOTAL_W-1:0] current_total;
  logic               last;

  int                 fail_count;
  int                 pending_count;
  int                 cycle_count;
  logic [TOTAL_W-1:0] writes_sent;
  bit                 steady_run;

  overwrite_log_ring_with_since_read_top #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .data_byte(data_byte), .since_total(since_total), .strobe(strobe),
    .byte_out(byte_out), .byte_valid(byte_valid), .overflow(overflow),
    .current_total(current_total), .last(last)
  );

  trace_ring_checker #(.DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .data_byte(data_byte), .since_total(since_total), .strobe(strobe),
    .byte_out(byte_out), .byte_valid(byte_valid), .overflow(overflow),
    .current_total(current_total), .last(last),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("overwrite_log_ring_with_since_read_top_tb NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_after();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      kind <= KIND_W'($urandom);
      data_byte <= BYTE_W'($urandom);
      since_total <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_command(input kind_t k, input logic [BYTE_W-1:0] d,
                              input logic [TOTAL_W-1:0] s);
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    data_byte <= d;
    since_total <= s;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (k == KIND_WRITE) writes_sent = writes_sent + 1'b1;
    idle_after();
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic send_read();
    int r;
    logic [TOTAL_W-1:0] cursor;
    r = $urandom_range(0, 99);
    if (r < 70) cursor = writes_sent - $urandom_range(0, DEPTH + 4);
    else if (r < 80) cursor = writes_sent;
    else if (r < 90) cursor = writes_sent + $urandom_range(1, 8);
    else cursor = $urandom;
    send_command(KIND_READ, BYTE_W'($urandom), cursor);
  endtask

  initial begin
    int items;
    int sel;
    int n;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_NONE;
    data_byte = '0;
    since_total = '0;
    writes_sent = '0;
    steady_run = 1'b0;
    items = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    send_command(KIND_READ, 8'h00, 32'h0000_0000);
    send_command(KIND_READ, 8'hFF, 32'hFFFF_FFFF);
    send_command(KIND_WRITE, 8'h00, 32'hFFFF_FFFF);
    send_command(KIND_WRITE, 8'hFF, 32'h0000_0000);
    send_command(KIND_WRITE, 8'hA5, 32'h0);
    send_command(KIND_WRITE, 8'h5A, 32'h0);
    send_command(KIND_READ, 8'h00, 32'd0);
    send_command(KIND_READ, 8'h00, 32'd2);
    send_command(KIND_READ, 8'h00, 32'd4);
    send_command(KIND_READ, 8'h00, 32'd5);
    send_command(KIND_NONE, 8'hFF, 32'hFFFF_FFFF);
    send_command(KIND_CLEAR, 8'h00, 32'h0);
    send_command(KIND_READ, 8'h00, 32'd0);
    send_command(KIND_WRITE, 8'h80, 32'h0);
    send_command(KIND_WRITE, 8'h01, 32'h0);
    send_command(KIND_READ, 8'h00, 32'd4);
    send_command(KIND_READ, 8'h00, 32'd0);
    send_command(KIND_READ, 8'h00, 32'h8000_0000);
    hold_until_drained();

    // random
    while (items < ITEM_GOAL) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) steady_run = !steady_run;
      if (sel < 45) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(DEPTH, DEPTH + 8)
                                        : $urandom_range(1, 12);
        repeat (n) send_command(KIND_WRITE, BYTE_W'($urandom), $urandom);
        items += n;
      end else if (sel < 85) begin
        send_read();
        items++;
      end else if (sel < 91) begin
        send_command(KIND_CLEAR, BYTE_W'($urandom), $urandom);
        items++;
      end else if (sel < 95) begin
        send_command(KIND_NONE, BYTE_W'($urandom), $urandom);
      end else begin
        hold_until_drained();
        send_read();
        items++;
      end
    end

    hold_until_drained();
    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("overwrite_log_ring_with_since_read_top_tb OK");
    end else begin
      $display("overwrite_log_ring_with_since_read_top_tb NOT OK");
    end
    $finish;
  end

endmodule
